>>> rtl/core/lapedge_pkg.sv
// ----------------------------------------------------------------------------
// lapedge_pkg
// Shared constants, types and helpers for the 3x3 Laplacian edge filter.
// ----------------------------------------------------------------------------
package lapedge_pkg;

    // Default line store depth (largest supported image width)
    localparam int MAX_WIDTH_DEF = 1024;

    // Configuration register widths and reset values
    localparam int IMG_W_BITS    = 11;
    localparam int IMG_H_BITS    = 12;
    localparam int CFG_DATA_BITS = 12;
    localparam logic [IMG_W_BITS-1:0] IMG_W_RST = 11'd640;
    localparam logic [IMG_H_BITS-1:0] IMG_H_RST = 12'd480;

    // Configuration register indexes
    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;

    // Pixel and doubled kernel sum widths
    localparam int PIX_BITS = 8;
    localparam int SUM_BITS = 13;

    // Result queue depth
    localparam int RES_DEPTH = 4;

    typedef logic signed [SUM_BITS-1:0] t_sum;

    typedef struct packed {
        logic [PIX_BITS-1:0] edge_value;
        logic                frame_last;
    } t_result;

    // Halve the doubled sum (truncating) and clamp to 0..255
    function automatic logic [PIX_BITS-1:0] saturate(input t_sum s2);
        logic [PIX_BITS-1:0] res;
        if (s2 <= t_sum'(0)) begin
            res = '0;
        end else if (s2 >= t_sum'(512)) begin
            res = '1;
        end else begin
            res = s2[PIX_BITS:1];
        end
        return res;
    endfunction

endpackage

>>> rtl/core/laplacian_edge_3x3_top.sv
// ----------------------------------------------------------------------------
// laplacian_edge_3x3_top
// 3x3 Laplacian edge filter on a raster stream of 8-bit pixels.
// ----------------------------------------------------------------------------
// Usage:
//   Pixels enter on the valid/ready channel i_pixel_valid / o_pixel_ready in
//   raster order, one transaction per pixel. Each interior pixel (not on the
//   first or last row or column) yields one transaction on o_edge_valid /
//   i_edge_ready; o_frame_last marks the last result of an image.
//   Border pixels give no output transaction.
//   The result for centre (r-1, c-1) belongs to the transaction of pixel
//   (r, c). It goes through the line store read at acceptance, then the
//   window update and kernel sum, then saturation into the result queue,
//   from which results are taken in order. Throughput is one pixel per
//   clock while o_pixel_ready is high: each line store sees one read and
//   one write per cycle, always to different columns, so no interlock is
//   needed.
//   Image size is set on the write port (index 0 width, index 1 height);
//   a write also restarts the frame at row 0, column 0. Write only while idle.
//   Reset clears the counters, window, pipeline and result queue and loads
//   640x480; the line stores are not cleared (the first two rows of every
//   frame refill them before any result uses them), so there is no clearing
//   pass. When the receiver stalls, the four-entry result queue absorbs the
//   results in flight and o_pixel_ready drops once it would overflow.
// ----------------------------------------------------------------------------
module laplacian_edge_3x3_top #(
    parameter int MAX_WIDTH = lapedge_pkg::MAX_WIDTH_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // configuration write port
    input  logic                                  i_cfg_we,
    input  logic                                  i_cfg_idx,
    input  logic [lapedge_pkg::CFG_DATA_BITS-1:0] i_cfg_wdata,
    // pixel input channel
    input  logic                                  i_pixel_valid,
    output logic                                  o_pixel_ready,
    input  logic [lapedge_pkg::PIX_BITS-1:0]      i_pixel_value,
    // result output channel
    output logic                                  o_edge_valid,
    input  logic                                  i_edge_ready,
    output logic [lapedge_pkg::PIX_BITS-1:0]      o_edge_value,
    output logic                                  o_frame_last
);

    localparam int ADDR_W = $clog2(MAX_WIDTH);
    localparam int CW     = $clog2(MAX_WIDTH + 1);
    localparam int EW     = (CW > lapedge_pkg::IMG_W_BITS) ? CW : lapedge_pkg::IMG_W_BITS;
    localparam int PW     = lapedge_pkg::PIX_BITS;
    localparam int HW     = lapedge_pkg::IMG_H_BITS;
    localparam int QD     = lapedge_pkg::RES_DEPTH;
    localparam int QA     = $clog2(QD);
    localparam int QC     = $clog2(QD + 1);
    localparam int SB     = lapedge_pkg::SUM_BITS;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [lapedge_pkg::IMG_W_BITS-1:0] r_image_width;
    logic [HW-1:0]                      r_image_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= lapedge_pkg::IMG_W_RST;
            r_image_height <= lapedge_pkg::IMG_H_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                lapedge_pkg::REG_IMAGE_WIDTH: begin
                    r_image_width <= i_cfg_wdata[lapedge_pkg::IMG_W_BITS-1:0];
                end
                lapedge_pkg::REG_IMAGE_HEIGHT: begin
                    r_image_height <= i_cfg_wdata[HW-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Clamp width to 3..MAX_WIDTH and height to at least 3
    logic [EW-1:0]     width_ext;
    logic [EW-1:0]     width_eff;
    logic [ADDR_W-1:0] last_col;
    logic [HW-1:0]     last_row;

    always_comb begin
        width_ext = EW'(r_image_width);
        if (width_ext < EW'(3)) begin
            width_eff = EW'(3);
        end else if (width_ext > EW'(MAX_WIDTH)) begin
            width_eff = EW'(MAX_WIDTH);
        end else begin
            width_eff = width_ext;
        end
        last_col = ADDR_W'(width_eff - EW'(1));
        if (r_image_height < HW'(3)) begin
            last_row = HW'(2);
        end else begin
            last_row = r_image_height - HW'(1);
        end
    end

    // ------------------------------------------------------------------
    // Raster position counters
    // ------------------------------------------------------------------
    logic              pix_accept;
    logic [ADDR_W-1:0] r_col;
    logic [HW-1:0]     r_row;
    logic [ADDR_W-1:0] n_col;
    logic [HW-1:0]     n_row;
    logic              col_end;
    logic              row_end;

    assign pix_accept = i_pixel_valid && o_pixel_ready;
    assign col_end    = (r_col == last_col);
    assign row_end    = (r_row == last_row);

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (pix_accept) begin
            if (col_end) begin
                n_col = '0;
                n_row = row_end ? '0 : r_row + HW'(1);
            end else begin
                n_col = r_col + ADDR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_cfg_we) begin
            // restart the frame on any register write
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: line store read issued at acceptance
    // ------------------------------------------------------------------
    logic              r_s1_valid;
    logic              r_s1_emit;
    logic              r_s1_last;
    logic [ADDR_W-1:0] r_s1_col;
    logic [PW-1:0]     r_s1_px;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s1_emit  <= 1'b0;
            r_s1_last  <= 1'b0;
        end else begin
            r_s1_valid <= pix_accept;
            r_s1_emit  <= pix_accept && (r_row >= HW'(2)) && (r_col >= ADDR_W'(2));
            r_s1_last  <= pix_accept && row_end && col_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pix_accept) begin
            r_s1_col <= r_col;
            r_s1_px  <= i_pixel_value;
        end
    end

    // Line stores: read the column at acceptance, write it back from the
    // stage 1 registers. Consecutive pixels always hit different columns.
    logic [PW-1:0] r_mem_upper [MAX_WIDTH];
    logic [PW-1:0] r_mem_middle [MAX_WIDTH];
    logic [PW-1:0] r_rd_upper;
    logic [PW-1:0] r_rd_middle;

    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_mem_upper[r_s1_col] <= r_rd_middle;
        end
        if (pix_accept) begin
            r_rd_upper <= r_mem_upper[r_col];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_mem_middle[r_s1_col] <= r_s1_px;
        end
        if (pix_accept) begin
            r_rd_middle <= r_mem_middle[r_col];
        end
    end

    // ------------------------------------------------------------------
    // Window shift and doubled kernel sum
    // ------------------------------------------------------------------
    logic [PW-1:0] r_win [9];
    logic [PW-1:0] n_win [9];

    always_comb begin
        for (int k = 0; k < 9; k++) begin
            n_win[k] = r_win[k];
        end
        if (r_s1_valid) begin
            for (int rw = 0; rw < 3; rw++) begin
                n_win[rw*3]     = r_win[rw*3 + 1];
                n_win[rw*3 + 1] = r_win[rw*3 + 2];
            end
            n_win[2] = r_rd_upper;
            n_win[5] = r_rd_middle;
            n_win[8] = r_s1_px;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 9; k++) begin
                r_win[k] <= '0;
            end
        end else begin
            for (int k = 0; k < 9; k++) begin
                r_win[k] <= n_win[k];
            end
        end
    end

    logic [SB-1:0] corners;
    logic [SB-1:0] edges;
    logic [SB-1:0] centre12;
    logic [SB-1:0] sum2;

    always_comb begin
        corners  = SB'(n_win[0]) + SB'(n_win[2]) + SB'(n_win[6]) + SB'(n_win[8]);
        edges    = SB'(n_win[1]) + SB'(n_win[3]) + SB'(n_win[5]) + SB'(n_win[7]);
        centre12 = (SB'(n_win[4]) << 3) + (SB'(n_win[4]) << 2);
        sum2     = corners + (edges << 1) - centre12;
    end

    // ------------------------------------------------------------------
    // Stage 2: registered sum, then saturate into the result queue
    // ------------------------------------------------------------------
    logic                 r_s2_valid;
    logic                 r_s2_last;
    lapedge_pkg::t_sum    r_s2_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= r_s1_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_emit) begin
            r_s2_sum  <= lapedge_pkg::t_sum'(sum2);
            r_s2_last <= r_s1_last;
        end
    end

    // Result queue
    lapedge_pkg::t_result r_queue [QD];
    lapedge_pkg::t_result push_data;
    logic [QA-1:0]        r_wr_ptr;
    logic [QA-1:0]        r_rd_ptr;
    logic [QC-1:0]        r_q_count;
    logic                 q_pop;
    logic [QC:0]          in_flight;

    assign push_data.edge_value = lapedge_pkg::saturate(r_s2_sum);
    assign push_data.frame_last = r_s2_last;
    assign q_pop                = o_edge_valid && i_edge_ready;

    always_ff @(posedge i_clk) begin
        if (r_s2_valid) begin
            r_queue[r_wr_ptr] <= push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr  <= '0;
            r_rd_ptr  <= '0;
            r_q_count <= '0;
        end else begin
            if (r_s2_valid) begin
                r_wr_ptr <= r_wr_ptr + QA'(1);
            end
            if (q_pop) begin
                r_rd_ptr <= r_rd_ptr + QA'(1);
            end
            case ({r_s2_valid, q_pop})
                2'b10:   r_q_count <= r_q_count + QC'(1);
                2'b01:   r_q_count <= r_q_count - QC'(1);
                default: r_q_count <= r_q_count;
            endcase
        end
    end

    // Hold off input once the queue could not take every result in flight
    assign in_flight     = (QC+1)'(r_q_count) + (QC+1)'(r_s1_emit) + (QC+1)'(r_s2_valid);
    assign o_pixel_ready = (in_flight < (QC+1)'(QD));

    assign o_edge_valid = (r_q_count != '0);
    assign o_edge_value = r_queue[r_rd_ptr].edge_value;
    assign o_frame_last = r_queue[r_rd_ptr].frame_last;

`ifndef SYNTHESIS
    // Results in flight never exceed the queue space
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_flight <= (QC+1)'(QD))
        else $error("result queue overflow");

    // A result is only produced away from the left border
    a_interior_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_emit |-> (r_s1_valid && (r_s1_col >= ADDR_W'(2))))
        else $error("result outside interior columns");

    // Frame end marker travels only with a result
    a_last_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_last |-> r_s1_emit)
        else $error("frame end without result");

    // Read and write-back never address the same column in one cycle
    a_no_collision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && pix_accept) |-> (r_s1_col != r_col))
        else $error("line store read/write collision");

    // The output is valid in the cycle after a result is pushed
    a_push_visible: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_valid |=> o_edge_valid)
        else $error("pushed result not visible");
`endif

endmodule

>>> test/tb_laplacian_edge_3x3_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_laplacian_edge_3x3_top
// Self-checking bench for the 3x3 Laplacian edge filter. Pixel frames are fed
// under several image sizes, out-of-range and extreme ones included. A local
// model of the line stores, window and counters predicts every interior
// result, and each output transaction is compared with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_laplacian_edge_3x3_top;

    localparam int LINE_DEPTH  = lapedge_pkg::MAX_WIDTH_DEF;
    localparam int PIX_W       = lapedge_pkg::PIX_BITS;
    localparam int CFG_W       = lapedge_pkg::CFG_DATA_BITS;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int LONG_HOLD   = 400;
    localparam int DRAIN_WAIT  = 12;
    localparam int RANDOM_ITEMS = 1000;

    // pixel styles for random frames
    typedef enum int {
        STYLE_UNIFORM,
        STYLE_SMOOTH,
        STYLE_BINARY,
        STYLE_SPIKES
    } t_pixel_style;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_cfg_we = 1'b0;
    logic                     i_cfg_idx = lapedge_pkg::REG_IMAGE_WIDTH;
    logic [CFG_W-1:0]         i_cfg_wdata = '0;
    logic                     i_pixel_valid = 1'b0;
    logic                     o_pixel_ready;
    logic [PIX_W-1:0]         i_pixel_value = '0;
    logic                     o_edge_valid;
    logic                     i_edge_ready = 1'b0;
    logic [PIX_W-1:0]         o_edge_value;
    logic                     o_frame_last;

    laplacian_edge_3x3_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_pixel_valid (i_pixel_valid),
        .o_pixel_ready (o_pixel_ready),
        .i_pixel_value (i_pixel_value),
        .o_edge_valid  (o_edge_valid),
        .i_edge_ready  (i_edge_ready),
        .o_edge_value  (o_edge_value),
        .o_frame_last  (o_frame_last)
    );

    always #1 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Filter model: own copy of the size registers, line stores, window
    // and raster counters.
    // ------------------------------------------------------------------
    logic [lapedge_pkg::IMG_W_BITS-1:0] cfg_width  = lapedge_pkg::IMG_W_RST;
    logic [lapedge_pkg::IMG_H_BITS-1:0] cfg_height = lapedge_pkg::IMG_H_RST;
    logic [PIX_W-1:0]      upper_line  [LINE_DEPTH];
    logic [PIX_W-1:0]      middle_line [LINE_DEPTH];
    logic [PIX_W-1:0]      win [9];
    int unsigned           col_pos = 0;
    int unsigned           row_pos = 0;

    lapedge_pkg::t_result  expected_edges [$];
    logic [PIX_W-1:0]      pixel_queue [$];
    int unsigned           pixels_queued = 0;
    int unsigned           pixels_taken  = 0;
    int unsigned           failures      = 0;
    int unsigned           cycles        = 0;

    // idling control shared by driver, monitor and sequencer
    bit                    quiet_tail   = 1'b0;
    bit                    hold_request = 1'b0;
    bit                    hold_done    = 1'b0;
    int unsigned           tx_gap       = 0;
    int unsigned           rx_stall     = 0;
    int unsigned           hold_left    = 0;

    // Clamp the width register into 3..MAX_WIDTH
    function automatic int unsigned eff_width();
        int unsigned w;
        w = cfg_width;
        if (w < 3) w = 3;
        if (w > LINE_DEPTH) w = LINE_DEPTH;
        return w;
    endfunction

    function automatic int unsigned eff_height();
        return (cfg_height < 3) ? 3 : int'(cfg_height);
    endfunction

    // Advance the model by one accepted pixel; queue a result for interior centres
    task automatic predict_pixel(input logic [PIX_W-1:0] px);
        int unsigned w;
        int unsigned h;
        int unsigned c;
        int unsigned r;
        int          s2;
        logic [PIX_W-1:0] up;
        logic [PIX_W-1:0] mid;
        lapedge_pkg::t_result res;
        w = eff_width();
        h = eff_height();
        c = col_pos;
        r = row_pos;
        up  = upper_line[c];
        mid = middle_line[c];
        for (int k = 0; k < 3; k++) begin
            win[k*3]   = win[k*3+1];
            win[k*3+1] = win[k*3+2];
        end
        win[2] = up;
        win[5] = mid;
        win[8] = px;
        upper_line[c]  = mid;
        middle_line[c] = px;
        if (r >= 2 && c >= 2) begin
            // doubled sum: corners weigh 1, edges 2, centre -12
            s2 = int'(win[0]) + int'(win[2]) + int'(win[6]) + int'(win[8])
               + 2 * (int'(win[1]) + int'(win[3]) + int'(win[5]) + int'(win[7]))
               - 12 * int'(win[4]);
            if (s2 <= 0) begin
                res.edge_value = '0;
            end else if (s2 >= 512) begin
                res.edge_value = '1;
            end else begin
                res.edge_value = PIX_W'(s2 / 2);
            end
            res.frame_last = (r == h - 1) && (c == w - 1);
            expected_edges.push_back(res);
        end
        if (c + 1 >= w) begin
            col_pos = 0;
            row_pos = (r + 1 >= h) ? 0 : r + 1;
        end else begin
            col_pos = c + 1;
        end
    endtask

    // ------------------------------------------------------------------
    // Driver: take pixels from pixel_queue, hold each one on the bus until
    // its transaction completes, and feed the model on acceptance.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_pixel_valid <= 1'b0;
        end else begin
            if (i_pixel_valid && o_pixel_ready) begin
                predict_pixel(i_pixel_value);
                pixels_taken++;
            end
            // the bus is free when nothing is offered or the offer was just taken
            if (!i_pixel_valid || o_pixel_ready) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    i_pixel_valid <= 1'b0;
                end else if (pixel_queue.size() != 0) begin
                    i_pixel_valid <= 1'b1;
                    i_pixel_value <= pixel_queue.pop_front();
                    // occasionally idle after this transaction
                    if (!quiet_tail && $urandom_range(0, 9) == 0) begin
                        tx_gap = $urandom_range(1, 19);
                    end
                end else begin
                    i_pixel_valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off: count it down here, the monitor obeys it
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (hold_request && !hold_done) begin
            hold_left <= LONG_HOLD;
            hold_done <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compare every result transaction with the oldest prediction,
    // and throttle i_edge_ready in random bursts plus one long hold-off.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        lapedge_pkg::t_result exp_res;
        logic    rdy_next;
        if (!i_rst_n) begin
            i_edge_ready <= 1'b0;
        end else begin
            if (o_edge_valid && i_edge_ready) begin
                if (expected_edges.size() == 0) begin
                    $error("unexpected result: edge_value %0d frame_last %0b",
                           o_edge_value, o_frame_last);
                    failures++;
                end else begin
                    exp_res = expected_edges.pop_front();
                    if (o_edge_value !== exp_res.edge_value) begin
                        $error("edge_value mismatch: expected %0d, actual %0d",
                               exp_res.edge_value, o_edge_value);
                        failures++;
                    end
                    if (o_frame_last !== exp_res.frame_last) begin
                        $error("frame_last mismatch: expected %0b, actual %0b",
                               exp_res.frame_last, o_frame_last);
                        failures++;
                    end
                end
            end
            // long hold-off: the result queue fills and the input must stall
            if (hold_left > 0) begin
                rdy_next = 1'b0;
            end else if (rx_stall > 0) begin
                rx_stall--;
                rdy_next = 1'b0;
            end else begin
                rdy_next = 1'b1;
                if (!quiet_tail && $urandom_range(0, 9) == 0) begin
                    rx_stall = $urandom_range(1, 19);
                end
            end
            i_edge_ready <= rdy_next;
        end
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer helpers
    // ------------------------------------------------------------------

    // Write the size registers; call right after a rising edge, with the block idle
    task automatic set_size(input bit write_w, input int unsigned w,
                            input bit write_h, input int unsigned h);
        if (write_w) begin
            i_cfg_we    <= 1'b1;
            i_cfg_idx   <= lapedge_pkg::REG_IMAGE_WIDTH;
            i_cfg_wdata <= w[CFG_W-1:0];
            @(posedge i_clk);
            cfg_width = w[lapedge_pkg::IMG_W_BITS-1:0];
            col_pos = 0;
            row_pos = 0;
        end
        if (write_h) begin
            i_cfg_we    <= 1'b1;
            i_cfg_idx   <= lapedge_pkg::REG_IMAGE_HEIGHT;
            i_cfg_wdata <= h[CFG_W-1:0];
            @(posedge i_clk);
            cfg_height = h[lapedge_pkg::IMG_H_BITS-1:0];
            col_pos = 0;
            row_pos = 0;
        end
        i_cfg_we <= 1'b0;
    endtask

    task automatic push_pixel(input logic [PIX_W-1:0] px);
        pixel_queue.push_back(px);
        pixels_queued++;
    endtask

    // One 3x3 frame: corners, edge neighbours and centre each of one value
    task automatic push_ring(input logic [PIX_W-1:0] corner,
                             input logic [PIX_W-1:0] side,
                             input logic [PIX_W-1:0] centre);
        push_pixel(corner); push_pixel(side);   push_pixel(corner);
        push_pixel(side);   push_pixel(centre); push_pixel(side);
        push_pixel(corner); push_pixel(side);   push_pixel(corner);
    endtask

    // Wait for every pixel to be taken and every result to arrive, then let
    // the pipeline drain of pixels that produce no result
    task automatic wait_idle();
        while (pixels_taken != pixels_queued || expected_edges.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    function automatic logic [PIX_W-1:0] draw_pixel(input t_pixel_style style,
                                                    input int unsigned base);
        int unsigned v;
        case (style)
            STYLE_SMOOTH: begin
                v = base + $urandom_range(0, 15);
            end
            STYLE_BINARY: begin
                v = $urandom_range(0, 1) ? 255 : 0;
            end
            STYLE_SPIKES: begin
                v = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 255) : base;
            end
            default: begin
                v = $urandom_range(0, 255);
            end
        endcase
        return (v > 255) ? 8'hFF : v[PIX_W-1:0];
    endfunction

    // Random frame stream under one size; long frames are cut short
    task automatic random_phase(input int unsigned w, input int unsigned h,
                                input bit write_w, input bit write_h,
                                output int unsigned n_items);
        int unsigned  ew;
        int unsigned  eh;
        int unsigned  frame_px;
        int unsigned  base;
        t_pixel_style style;
        set_size(write_w, w, write_h, h);
        ew = eff_width();
        eh = eff_height();
        frame_px = ew * eh;
        if (frame_px <= 150) begin
            n_items = frame_px * $urandom_range(1, 3);
            if ($urandom_range(0, 1)) n_items += $urandom_range(0, frame_px - 1);
        end else begin
            // partial frame, restarted by the next register write
            n_items = $urandom_range(2 * ew + 3, 2 * ew + 60);
        end
        style = t_pixel_style'($urandom_range(0, 3));
        base  = $urandom_range(0, 240);
        for (int k = 0; k < n_items; k++) begin
            push_pixel(draw_pixel(style, base));
        end
        wait_idle();
    endtask

    // ------------------------------------------------------------------
    // Stimulus sequence
    // ------------------------------------------------------------------
    initial begin
        int unsigned random_items;
        int unsigned n;
        int unsigned w;
        int unsigned h;
        int unsigned pick;
        bit          ww;
        bit          wh;

        for (int k = 0; k < LINE_DEPTH; k++) begin
            upper_line[k]  = '0;
            middle_line[k] = '0;
        end
        for (int k = 0; k < 9; k++) win[k] = '0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset size 640x480: part of a first row, no result may appear
        for (int k = 0; k < 40; k++) push_pixel($urandom_range(0, 255));
        wait_idle();

        // directed: smallest frames, kernel extremes and truncation of halves
        set_size(1'b1, 3, 1'b1, 3);
        push_ring(8'd255, 8'd255, 8'd0);
        push_ring(8'd0, 8'd0, 8'd255);
        push_pixel(8'd3);
        for (int k = 0; k < 8; k++) push_pixel(8'd0);
        // stop mid-frame so the next write restarts it
        push_pixel(8'd17);
        push_pixel(8'd200);
        wait_idle();

        // wide image, one complete frame with its frame end marker
        set_size(1'b1, 150, 1'b1, 3);
        for (int k = 0; k < 450; k++) push_pixel($urandom_range(0, 255));
        wait_idle();

        // zero sizes act as 3x3
        set_size(1'b1, 0, 1'b1, 0);
        for (int k = 0; k < 27; k++) push_pixel($urandom_range(0, 255));
        wait_idle();

        // width with bit 11 set lands in the 11-bit register as 5; height 1 as 3
        set_size(1'b1, 12'h805, 1'b1, 1);
        for (int k = 0; k < 30; k++) push_pixel($urandom_range(0, 255));
        wait_idle();

        // random part; the first phase runs under the long receiver hold-off
        random_items = 0;
        hold_request = 1'b1;
        random_phase(4, 12, 1'b1, 1'b1, n);
        random_items += n;
        while (random_items < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 19);
            if (pick < 2) begin
                w = $urandom_range(0, 2);
            end else if (pick < 4) begin
                w = $urandom_range(13, 40);
            end else begin
                w = $urandom_range(3, 12);
            end
            pick = $urandom_range(0, 19);
            if (pick < 2) begin
                h = $urandom_range(0, 2);
            end else if (pick < 4) begin
                h = $urandom_range(9, 4095);
            end else begin
                h = $urandom_range(3, 8);
            end
            // sometimes rewrite only one register
            pick = $urandom_range(0, 3);
            ww = (pick != 1);
            wh = (pick != 2);
            random_phase(w, h, ww, wh, n);
            random_items += n;
        end

        // closing stretch at full rate on both sides
        quiet_tail = 1'b1;
        random_phase(6, 5, 1'b1, 1'b1, n);

        wait_idle();
        if (failures == 0 && expected_edges.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

>>> laplacian_edge_3x3_top.f
rtl/core/lapedge_pkg.sv
rtl/core/laplacian_edge_3x3_top.sv
test/tb_laplacian_edge_3x3_top.sv
